[sv/rdsp_pkg.sv]
// Shared types and constants for the radix digit string parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rdsp_pkg;

  localparam int VALUE_WIDTH = 32;
  // Headroom for value * 16 + 15 without wrap.
  localparam int SUM_WIDTH   = VALUE_WIDTH + 4;
  localparam int CHAR_WIDTH  = 8;
  localparam int DIGIT_WIDTH = 4;
  localparam int RADIX_WIDTH = 5;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_code_t;

  localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_F = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_F = 8'h46;
  // Offsets that map a letter straight to its digit value 10..15.
  localparam logic [CHAR_WIDTH-1:0] LOWER_OFS  = CH_LOWER_A - 8'd10;
  localparam logic [CHAR_WIDTH-1:0] UPPER_OFS  = CH_UPPER_A - 8'd10;

  typedef struct packed {
    logic                   ok;
    logic [DIGIT_WIDTH-1:0] value;
  } digit_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   invalid;
    logic                   saturated;
  } result_t;

  function automatic logic [RADIX_WIDTH-1:0] radix_of(radix_code_t code);
    logic [RADIX_WIDTH-1:0] r;
    unique case (code)
      RADIX_DEC: r = 5'd10;
      RADIX_BIN: r = 5'd2;
      RADIX_OCT: r = 5'd8;
      RADIX_HEX: r = 5'd16;
      default:   r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/rdsp_digit.sv]
// Character to digit decoder: checks one ASCII character against a radix.
// Depends on rdsp_pkg.
`default_nettype none

module rdsp_digit (
  input  wire logic [rdsp_pkg::CHAR_WIDTH-1:0] char_code,
  input  rdsp_pkg::radix_code_t                radix_code,
  output rdsp_pkg::digit_t                     digit
);
  import rdsp_pkg::*;

  logic [CHAR_WIDTH-1:0]  diff;
  logic                   in_set;
  logic [RADIX_WIDTH-1:0] radix;

  always_comb begin
    diff   = '0;
    in_set = 1'b0;
    priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      diff   = char_code - CH_ZERO;
      in_set = 1'b1;
    end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_F) begin
      diff   = char_code - LOWER_OFS;
      in_set = 1'b1;
    end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_F) begin
      diff   = char_code - UPPER_OFS;
      in_set = 1'b1;
    end else begin
      in_set = 1'b0;
    end
  end

  assign radix       = radix_of(radix_code);
  assign digit.value = diff[DIGIT_WIDTH-1:0];
  // Reject digits at or above the radix.
  assign digit.ok    = in_set && ({1'b0, diff[DIGIT_WIDTH-1:0]} < radix);

endmodule

`default_nettype wire

[sv/rdsp_accum.sv]
// Per-string state: latched radix, running value and error flags.
// Depends on rdsp_pkg and rdsp_digit.
`default_nettype none

module rdsp_accum (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step,
  input  wire logic [rdsp_pkg::CHAR_WIDTH-1:0]  char_code,
  input  rdsp_pkg::radix_code_t                 radix_code,
  input  wire logic                             is_last,
  output rdsp_pkg::result_t                     result
);
  import rdsp_pkg::*;

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   bad_r, bad_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   start_r, start_nxt;
  radix_code_t            radix_r, radix_nxt;

  logic [VALUE_WIDTH-1:0] acc_cur;
  logic                   bad_cur;
  logic                   ovf_cur;
  logic [SUM_WIDTH-1:0]   acc_ext;
  logic [SUM_WIDTH-1:0]   prod;
  logic [SUM_WIDTH-1:0]   sum;
  digit_t                 digit;

  // A new string starts from a clean slate and takes the incoming radix.
  assign radix_nxt = start_r ? radix_code : radix_r;
  assign acc_cur   = start_r ? '0 : acc_r;
  assign bad_cur   = start_r ? 1'b0 : bad_r;
  assign ovf_cur   = start_r ? 1'b0 : ovf_r;

  rdsp_digit u_digit (
    .char_code  (char_code),
    .radix_code (radix_nxt),
    .digit      (digit)
  );

  assign acc_ext = {{(SUM_WIDTH-VALUE_WIDTH){1'b0}}, acc_cur};

  always_comb begin
    unique case (radix_nxt)
      RADIX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
      RADIX_BIN: prod = acc_ext << 1;
      RADIX_OCT: prod = acc_ext << 3;
      RADIX_HEX: prod = acc_ext << 4;
      default:   prod = acc_ext;
    endcase
  end

  assign sum = prod + {{(SUM_WIDTH-DIGIT_WIDTH){1'b0}}, digit.value};

  always_comb begin
    acc_nxt = acc_cur;
    bad_nxt = bad_cur;
    ovf_nxt = ovf_cur;
    priority if (!digit.ok) begin
      bad_nxt = 1'b1;
    end else if (!ovf_cur) begin
      if (|sum[SUM_WIDTH-1:VALUE_WIDTH]) begin
        ovf_nxt = 1'b1;
        acc_nxt = '1;
      end else begin
        acc_nxt = sum[VALUE_WIDTH-1:0];
      end
    end else begin
      acc_nxt = acc_cur;
    end
  end

  assign start_nxt = is_last;

  // An invalid string reports zero and never saturated.
  assign result.value     = bad_nxt ? '0 : acc_nxt;
  assign result.invalid   = bad_nxt;
  assign result.saturated = !bad_nxt && ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      bad_r   <= 1'b0;
      ovf_r   <= 1'b0;
      start_r <= 1'b1;
      radix_r <= RADIX_DEC;
    end else if (step) begin
      acc_r   <= acc_nxt;
      bad_r   <= bad_nxt;
      ovf_r   <= ovf_nxt;
      start_r <= start_nxt;
      radix_r <= radix_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/radix_digit_string_parser.sv]
// Radix digit string parser, top level: input register, state update, result register.
// An accepted last character passes the input register and then the result register to out_*.
// Throughput: one character per cycle unless a last character stalls on the result register;
//   the per-character radix multiply-add is a shift-add between input and state registers.
// Reset: synchronous, active low; clears the pipeline valids and string state.
// Depends on rdsp_pkg and rdsp_accum.
`default_nettype none

module radix_digit_string_parser (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input characters.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] char_code
  input  wire logic [1:0]                         in_tuser,   // [1:0] radix_code
  input  wire logic                               in_tlast,   // is_last
  // Parsed values.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rdsp_pkg::VALUE_WIDTH-1:0]        out_tdata,  // [31:0] value
  output logic [1:0]                              out_tuser   // [0] invalid, [1] saturated
);
  import rdsp_pkg::*;

  // Input register: one character waiting to be folded into the state.
  logic                  in_valid_r;
  logic [CHAR_WIDTH-1:0] char_r;
  radix_code_t           radix_r;
  logic                  last_r;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   invalid_r;
  logic                   saturated_r;

  logic    out_free;
  logic    advance;
  result_t result;

  // Only the last character of a string needs room in the result register;
  // every other character folds into the state at once.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Hold the payload while the register stalls.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r  <= in_tdata;
      radix_r <= radix_code_t'(in_tuser);
      last_r  <= in_tlast;
    end
  end

  rdsp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .char_code  (char_r),
    .radix_code (radix_r),
    .is_last    (last_r),
    .result     (result)
  );

  // Load a result when a last character advances; drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (advance && last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      value_r     <= result.value;
      invalid_r   <= result.invalid;
      saturated_r <= result.saturated;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = {saturated_r, invalid_r};

endmodule

`default_nettype wire
